@@ hdl/bstats_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstats_pkg
// Shared sizes, command/status bundles, opcodes and the fit microprogram.
// ----------------------------------------------------------------------------
package bstats_pkg;

    localparam int MAX_BARS = 1024;
    localparam int IDX_W    = $clog2(MAX_BARS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int PRICE_W  = 32;

    // running sums, sized for a full store
    localparam int SUMC_W = PRICE_W + IDX_W + 1;
    localparam int SXY_W  = PRICE_W + 2 * IDX_W + 1;
    localparam int SX2Y_W = PRICE_W + 3 * IDX_W + 1;
    localparam int SYY_W  = 2 * PRICE_W + IDX_W + 1;
    localparam int SI_W   = 2 * IDX_W;
    localparam int SI2_W  = 3 * IDX_W;
    localparam int SI4_W  = 5 * IDX_W;

    // fit arithmetic word and sequencing
    localparam int WORD_W   = 192;
    localparam int STEP_W   = $clog2(WORD_W);
    localparam int RA_W     = 5;
    localparam int RF_DEPTH = 1 << RA_W;
    localparam int PC_W     = 6;

    localparam int EPS_SQ  = 1000;
    localparam int ONE_FIX = 65536;

    localparam logic [2:0] OP_LD  = 3'd0;
    localparam logic [2:0] OP_MUL = 3'd1;
    localparam logic [2:0] OP_ADD = 3'd2;
    localparam logic [2:0] OP_SUB = 3'd3;
    localparam logic [2:0] OP_DIV = 3'd4;
    localparam logic [2:0] OP_END = 3'd5;

    // register file slots: loaded operands first, then temporaries
    localparam logic [RA_W-1:0] RG_N    = 5'd0;
    localparam logic [RA_W-1:0] RG_SX   = 5'd1;
    localparam logic [RA_W-1:0] RG_SX2  = 5'd2;
    localparam logic [RA_W-1:0] RG_SY   = 5'd3;
    localparam logic [RA_W-1:0] RG_SXY  = 5'd4;
    localparam logic [RA_W-1:0] RG_SX2Y = 5'd5;
    localparam logic [RA_W-1:0] RG_SYY  = 5'd6;
    localparam logic [RA_W-1:0] RG_SX4  = 5'd7;
    localparam logic [RA_W-1:0] RG_EPSN = 5'd8;
    localparam logic [RA_W-1:0] RG_ONE  = 5'd9;
    localparam logic [RA_W-1:0] RG_NA   = 5'd10;
    localparam logic [RA_W-1:0] RG_NB   = 5'd11;
    localparam logic [RA_W-1:0] RG_T0   = 5'd12;
    localparam logic [RA_W-1:0] RG_T1   = 5'd13;
    localparam logic [RA_W-1:0] RG_NN   = 5'd14;
    localparam logic [RA_W-1:0] RG_SX3  = 5'd15;
    localparam logic [RA_W-1:0] RG_DD   = 5'd16;
    localparam logic [RA_W-1:0] RG_T    = 5'd17;
    localparam logic [RA_W-1:0] RG_DEN  = 5'd18;
    localparam logic [RA_W-1:0] RG_NUM  = 5'd19;
    localparam logic [RA_W-1:0] RG_C2   = 5'd20;
    localparam logic [RA_W-1:0] RG_C3   = 5'd21;
    localparam logic [RA_W-1:0] RG_DET  = 5'd22;
    localparam logic [RA_W-1:0] RG_DETA = 5'd23;

    // destination codes of a divide
    localparam logic [RA_W-1:0] RES_SLOPE = 5'd0;
    localparam logic [RA_W-1:0] RES_FIT   = 5'd1;
    localparam logic [RA_W-1:0] RES_CURV  = 5'd2;
    localparam logic [RA_W-1:0] RES_NOISE = 5'd3;

    typedef struct packed {
        logic [2:0]      op;
        logic [RA_W-1:0] d;
        logic [RA_W-1:0] a;
        logic [RA_W-1:0] b;
    } t_instr;

    typedef struct packed {
        logic            capture;
        logic            bar1;
        logic            bar2;
        logic            bar3;
        logic            ld;
        logic            rd;
        logic            alu_wr;
        logic            alu_sub;
        logic            mul_start;
        logic            mul_wr;
        logic            div_start;
        logic            res_wr;
        logic            emit;
        logic [RA_W-1:0] addr_d;
        logic [RA_W-1:0] addr_a;
        logic [RA_W-1:0] addr_b;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic mul_done;
        logic div_done;
    } t_stat;

    function automatic t_instr mk(input logic [2:0] op, input logic [RA_W-1:0] d,
                                  input logic [RA_W-1:0] a, input logic [RA_W-1:0] b);
        t_instr r;
        r.op = op;
        r.d  = d;
        r.a  = a;
        r.b  = b;
        return r;
    endfunction

    function automatic t_instr prog(input logic [PC_W-1:0] pc);
        t_instr r;
        unique case (pc)
            6'd0:  r = mk(OP_LD,  RG_N,    RG_N,    RG_N);
            6'd1:  r = mk(OP_LD,  RG_SX,   RG_N,    RG_N);
            6'd2:  r = mk(OP_LD,  RG_SX2,  RG_N,    RG_N);
            6'd3:  r = mk(OP_LD,  RG_SY,   RG_N,    RG_N);
            6'd4:  r = mk(OP_LD,  RG_SXY,  RG_N,    RG_N);
            6'd5:  r = mk(OP_LD,  RG_SX2Y, RG_N,    RG_N);
            6'd6:  r = mk(OP_LD,  RG_SYY,  RG_N,    RG_N);
            6'd7:  r = mk(OP_LD,  RG_SX4,  RG_N,    RG_N);
            6'd8:  r = mk(OP_LD,  RG_EPSN, RG_N,    RG_N);
            6'd9:  r = mk(OP_LD,  RG_ONE,  RG_N,    RG_N);
            6'd10: r = mk(OP_LD,  RG_NA,   RG_N,    RG_N);
            6'd11: r = mk(OP_LD,  RG_NB,   RG_N,    RG_N);
            // slope numerator and denominator
            6'd12: r = mk(OP_MUL, RG_T0,   RG_N,    RG_SXY);
            6'd13: r = mk(OP_MUL, RG_T1,   RG_SX,   RG_SY);
            6'd14: r = mk(OP_SUB, RG_NN,   RG_T0,   RG_T1);
            6'd15: r = mk(OP_MUL, RG_T0,   RG_N,    RG_SX2);
            6'd16: r = mk(OP_MUL, RG_SX3,  RG_SX,   RG_SX);
            6'd17: r = mk(OP_SUB, RG_DD,   RG_T0,   RG_SX3);
            6'd18: r = mk(OP_MUL, RG_T0,   RG_NN,   RG_ONE);
            6'd19: r = mk(OP_DIV, RES_SLOPE, RG_T0, RG_DD);
            // r squared
            6'd20: r = mk(OP_MUL, RG_T0,   RG_N,    RG_SYY);
            6'd21: r = mk(OP_MUL, RG_T1,   RG_SY,   RG_SY);
            6'd22: r = mk(OP_SUB, RG_T,    RG_T0,   RG_T1);
            6'd23: r = mk(OP_ADD, RG_T,    RG_T,    RG_EPSN);
            6'd24: r = mk(OP_MUL, RG_DEN,  RG_DD,   RG_T);
            6'd25: r = mk(OP_MUL, RG_T0,   RG_NN,   RG_NN);
            6'd26: r = mk(OP_MUL, RG_T1,   RG_DD,   RG_EPSN);
            6'd27: r = mk(OP_ADD, RG_NUM,  RG_T0,   RG_T1);
            6'd28: r = mk(OP_MUL, RG_NUM,  RG_NUM,  RG_ONE);
            6'd29: r = mk(OP_DIV, RES_FIT, RG_NUM,  RG_DEN);
            // quadratic cofactors
            6'd30: r = mk(OP_MUL, RG_T0,   RG_SX3,  RG_N);
            6'd31: r = mk(OP_MUL, RG_T1,   RG_SX,   RG_SX2);
            6'd32: r = mk(OP_SUB, RG_C2,   RG_T0,   RG_T1);
            6'd33: r = mk(OP_MUL, RG_T0,   RG_SX3,  RG_SX);
            6'd34: r = mk(OP_MUL, RG_T1,   RG_SX2,  RG_SX2);
            6'd35: r = mk(OP_SUB, RG_C3,   RG_T0,   RG_T1);
            6'd36: r = mk(OP_MUL, RG_T0,   RG_SX4,  RG_DD);
            6'd37: r = mk(OP_MUL, RG_T1,   RG_SX3,  RG_C2);
            6'd38: r = mk(OP_SUB, RG_DET,  RG_T0,   RG_T1);
            6'd39: r = mk(OP_MUL, RG_T0,   RG_SX2,  RG_C3);
            6'd40: r = mk(OP_ADD, RG_DET,  RG_DET,  RG_T0);
            6'd41: r = mk(OP_MUL, RG_T0,   RG_SX2Y, RG_DD);
            6'd42: r = mk(OP_MUL, RG_T1,   RG_SXY,  RG_C2);
            6'd43: r = mk(OP_SUB, RG_DETA, RG_T0,   RG_T1);
            6'd44: r = mk(OP_MUL, RG_T0,   RG_SY,   RG_C3);
            6'd45: r = mk(OP_ADD, RG_DETA, RG_DETA, RG_T0);
            6'd46: r = mk(OP_MUL, RG_DETA, RG_DETA, RG_ONE);
            6'd47: r = mk(OP_DIV, RES_CURV, RG_DETA, RG_DET);
            6'd48: r = mk(OP_DIV, RES_NOISE, RG_NA, RG_NB);
            default: r = mk(OP_END, RG_N,  RG_N,    RG_N);
        endcase
        return r;
    endfunction

endpackage

@@ hdl/bstats_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstats_dp
// Per-bar accumulators, register file, shift-add multiplier, rounding divider.
// ----------------------------------------------------------------------------
module bstats_dp import bstats_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [31:0]        i_open_price,
    input  logic [31:0]        i_close_price,
    input  logic               i_last_bar,
    output logic               o_valid,
    output logic [10:0]        o_bar_count,
    output logic signed [63:0] o_trend_slope,
    output logic [16:0]        o_fit_quality,
    output logic signed [63:0] o_curvature,
    output logic [47:0]        o_noise_ratio,
    output logic               o_overflowed
);

    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_PREP = 2'd1;
    localparam logic [1:0] DV_RUN  = 2'd2;
    localparam logic [1:0] DV_DONE = 2'd3;

    localparam logic [63:0] SAT_POS = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SAT_NEG = {1'b1, {63{1'b0}}};
    localparam logic [63:0] FIT_MAX = 64'(ONE_FIX);
    localparam logic [63:0] NOISE_MAX = {16'd0, {48{1'b1}}};

    // captured bar
    logic [PRICE_W-1:0] r_open, r_close;
    logic               r_last, r_keep;
    logic [IDX_W-1:0]   r_idx;
    // products
    logic [IDX_W+PRICE_W-1:0]   r_p_ic;
    logic [2*IDX_W-1:0]         r_p_i2;
    logic [2*PRICE_W-1:0]       r_p_cc;
    logic [PRICE_W-1:0]         r_p_mv;
    logic [2*IDX_W+PRICE_W-1:0] r_p_i2c;
    logic [4*IDX_W-1:0]         r_p_i4;
    // series state
    logic [CNT_W-1:0]   r_count;
    logic [PRICE_W-1:0] r_first_open, r_last_close;
    logic               r_dropped;
    logic [SUMC_W-1:0]  r_sum_mv, r_sum_c;
    logic [SXY_W-1:0]   r_sum_ic;
    logic [SX2Y_W-1:0]  r_sum_i2c;
    logic [SYY_W-1:0]   r_sum_cc;
    logic [SI_W-1:0]    r_sum_i;
    logic [SI2_W-1:0]   r_sum_i2;
    logic [SI4_W-1:0]   r_sum_i4;
    // register file
    logic [WORD_W-1:0] r_rf [0:RF_DEPTH-1];
    logic [WORD_W-1:0] r_rd_a, r_rd_b;
    logic [WORD_W-1:0] ld_data, rf_wd;
    logic              rf_we;
    // multiplier
    logic              r_mul_run;
    logic [WORD_W-1:0] r_ma, r_mb, r_acc;
    // divider
    logic [1:0]        r_dv_ph;
    logic [STEP_W-1:0] r_dv_cnt;
    logic              r_dv_neg, r_dv_zero;
    logic [WORD_W-1:0] r_num, r_den, r_rem;
    logic [WORD_W-1:0] rem_sh;
    logic              dv_ge;
    logic [63:0]       dv_mag, dv_res;
    // results
    logic [63:0]       r_slope, r_curv;
    logic [16:0]       r_fit;
    logic [47:0]       r_noise;
    logic              r_valid, r_out_ovf;
    logic [10:0]       r_out_count;
    // noise operands
    logic              single;
    logic [PRICE_W-1:0] tot;
    logic [CNT_W+9:0]  epsn;

    // ---------------- bar intake and products ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_open  <= i_open_price;
            r_close <= i_close_price;
            r_last  <= i_last_bar;
            r_keep  <= (r_count != CNT_W'(MAX_BARS));
            r_idx   <= r_count[IDX_W-1:0];
        end
        if (i_cmd.bar1) begin
            r_p_ic <= r_idx * r_close;
            r_p_i2 <= r_idx * r_idx;
            r_p_cc <= r_close * r_close;
            r_p_mv <= (r_close > r_open) ? r_close - r_open : r_open - r_close;
        end
        if (i_cmd.bar2) begin
            r_p_i2c <= r_p_i2 * r_close;
            r_p_i4  <= r_p_i2 * r_p_i2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_count      <= '0;
            r_first_open <= '0;
            r_last_close <= '0;
            r_dropped    <= 1'b0;
            r_sum_mv     <= '0;
            r_sum_c      <= '0;
            r_sum_ic     <= '0;
            r_sum_i2c    <= '0;
            r_sum_cc     <= '0;
            r_sum_i      <= '0;
            r_sum_i2     <= '0;
            r_sum_i4     <= '0;
        end else begin
            if (i_cmd.capture) begin
                if (r_count == CNT_W'(MAX_BARS)) begin
                    r_dropped <= 1'b1;
                end else if (r_count == '0) begin
                    r_first_open <= i_open_price;
                end
            end
            if (i_cmd.bar2 && r_keep) begin
                r_count      <= r_count + 1'b1;
                r_last_close <= r_close;
                r_sum_c      <= r_sum_c + SUMC_W'(r_close);
                r_sum_mv     <= r_sum_mv + SUMC_W'(r_p_mv);
                r_sum_ic     <= r_sum_ic + SXY_W'(r_p_ic);
                r_sum_cc     <= r_sum_cc + SYY_W'(r_p_cc);
                r_sum_i      <= r_sum_i + SI_W'(r_idx);
                r_sum_i2     <= r_sum_i2 + SI2_W'(r_p_i2);
            end
            if (i_cmd.bar3 && r_keep) begin
                r_sum_i2c <= r_sum_i2c + SX2Y_W'(r_p_i2c);
                r_sum_i4  <= r_sum_i4 + SI4_W'(r_p_i4);
            end
        end
    end

    // ---------------- operand loads ----------------
    assign single = (r_count == CNT_W'(1));
    assign tot    = (r_last_close > r_first_open) ? r_last_close - r_first_open
                                                  : r_first_open - r_last_close;
    assign epsn   = (CNT_W+10)'(r_count) * (CNT_W+10)'(EPS_SQ);

    always_comb begin
        unique case (i_cmd.addr_d)
            RG_N:    ld_data = WORD_W'(r_count);
            RG_SX:   ld_data = WORD_W'(r_sum_i);
            RG_SX2:  ld_data = WORD_W'(r_sum_i2);
            RG_SY:   ld_data = WORD_W'(r_sum_c);
            RG_SXY:  ld_data = WORD_W'(r_sum_ic);
            RG_SX2Y: ld_data = WORD_W'(r_sum_i2c);
            RG_SYY:  ld_data = WORD_W'(r_sum_cc);
            RG_SX4:  ld_data = WORD_W'(r_sum_i4);
            RG_EPSN: ld_data = WORD_W'(epsn);
            RG_ONE:  ld_data = WORD_W'(ONE_FIX);
            RG_NA:   ld_data = single ? (WORD_W'(r_sum_mv) << 16) : (WORD_W'(tot) << 16);
            RG_NB:   ld_data = single ? WORD_W'(1) : WORD_W'(r_sum_mv);
            default: ld_data = '0;
        endcase
    end

    // ---------------- register file ----------------
    assign rf_we = i_cmd.ld | i_cmd.alu_wr | i_cmd.mul_wr;

    always_comb begin
        priority if (i_cmd.ld) begin
            rf_wd = ld_data;
        end else if (i_cmd.mul_wr) begin
            rf_wd = r_acc;
        end else if (i_cmd.alu_sub) begin
            rf_wd = r_rd_a - r_rd_b;
        end else begin
            rf_wd = r_rd_a + r_rd_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[i_cmd.addr_d] <= rf_wd;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_rf[i_cmd.addr_a];
            r_rd_b <= r_rf[i_cmd.addr_b];
        end
    end

    // ---------------- shift-add multiplier, stops when multiplier drains ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_run <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_mul_run <= 1'b1;
        end else if (r_mul_run && r_mb == '0) begin
            r_mul_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma  <= r_rd_a;
            r_mb  <= r_rd_b;
            r_acc <= '0;
        end else if (r_mul_run && r_mb != '0) begin
            if (r_mb[0]) begin
                r_acc <= r_acc + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
    end

    // ---------------- rounding divider: (2|a|+|b|) / (2|b|), one bit a cycle ----------------
    assign rem_sh = {r_rem[WORD_W-2:0], r_num[WORD_W-1]};
    assign dv_ge  = (rem_sh >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_ph  <= DV_IDLE;
            r_dv_cnt <= '0;
        end else begin
            unique case (r_dv_ph)
                DV_IDLE: if (i_cmd.div_start) begin
                    r_dv_ph <= DV_PREP;
                end
                DV_PREP: begin
                    r_dv_ph  <= DV_RUN;
                    r_dv_cnt <= '0;
                end
                DV_RUN: begin
                    r_dv_cnt <= r_dv_cnt + 1'b1;
                    if (r_dv_cnt == STEP_W'(WORD_W - 1)) begin
                        r_dv_ph <= DV_DONE;
                    end
                end
                DV_DONE: if (i_cmd.res_wr) begin
                    r_dv_ph <= DV_IDLE;
                end
                default: r_dv_ph <= DV_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dv_neg  <= r_rd_a[WORD_W-1] ^ r_rd_b[WORD_W-1];
            r_dv_zero <= (r_rd_b == '0);
            r_num     <= r_rd_a[WORD_W-1] ? -r_rd_a : r_rd_a;
            r_den     <= r_rd_b[WORD_W-1] ? -r_rd_b : r_rd_b;
        end else if (r_dv_ph == DV_PREP) begin
            r_num <= (r_num << 1) + r_den;
            r_den <= r_den << 1;
            r_rem <= '0;
        end else if (r_dv_ph == DV_RUN) begin
            r_rem <= dv_ge ? rem_sh - r_den : rem_sh;
            r_num <= {r_num[WORD_W-2:0], dv_ge};
        end
    end

    // saturate the quotient to signed 64 bits, then apply the sign
    always_comb begin
        if (|r_num[WORD_W-1:63]) begin
            dv_mag = r_dv_neg ? SAT_NEG : SAT_POS;
        end else begin
            dv_mag = r_num[63:0];
        end
        if (r_dv_zero) begin
            dv_res = '0;
        end else begin
            dv_res = r_dv_neg ? -dv_mag : dv_mag;
        end
    end

    // ---------------- results ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_wr) begin
            unique case (i_cmd.addr_d)
                RES_SLOPE: r_slope <= dv_res;
                RES_FIT:   r_fit <= (dv_res > FIT_MAX) ? 17'(ONE_FIX) : dv_res[16:0];
                RES_CURV:  r_curv <= dv_res;
                RES_NOISE: r_noise <= (dv_res > NOISE_MAX) ? {48{1'b1}} : dv_res[47:0];
                default:   r_slope <= r_slope;
            endcase
        end
        if (i_cmd.emit) begin
            r_out_count <= 11'(r_count);
            r_out_ovf   <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.mul_done = r_mul_run && (r_mb == '0);
    assign o_stat.div_done = (r_dv_ph == DV_DONE);

    assign o_valid       = r_valid;
    assign o_bar_count   = r_out_count;
    assign o_trend_slope = r_slope;
    assign o_fit_quality = r_fit;
    assign o_curvature   = r_curv;
    assign o_noise_ratio = r_noise;
    assign o_overflowed  = r_out_ovf;

`ifndef ASSERT_OFF
    a_fit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fit_quality <= 17'(ONE_FIX)))
        else $error("fit quality above one");

    a_series_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_count == '0 && !r_dropped && o_valid))
        else $error("series not cleared on emit");

    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_ph != DV_IDLE) |-> !r_mul_run)
        else $error("multiplier and divider active together");
`endif

endmodule

@@ hdl/bstats_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstats_ctrl
// Bar intake sequencing and microprogram sequencer for the final fit.
// ----------------------------------------------------------------------------
module bstats_ctrl import bstats_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BAR1  = 4'd1;
    localparam logic [3:0] S_BAR2  = 4'd2;
    localparam logic [3:0] S_BAR3  = 4'd3;
    localparam logic [3:0] S_FETCH = 4'd4;
    localparam logic [3:0] S_OPER  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_instr          instr;

    assign instr = prog(r_pc);

    always_comb begin
        n_state       = r_state;
        n_pc          = r_pc;
        o_cmd         = '0;
        o_cmd.addr_d  = instr.d;
        o_cmd.addr_a  = instr.a;
        o_cmd.addr_b  = instr.b;
        unique case (r_state)
            S_IDLE: if (start) begin
                o_cmd.capture = 1'b1;
                n_state       = S_BAR1;
            end
            S_BAR1: begin
                o_cmd.bar1 = 1'b1;
                n_state    = S_BAR2;
            end
            S_BAR2: begin
                o_cmd.bar2 = 1'b1;
                n_state    = S_BAR3;
            end
            S_BAR3: begin
                o_cmd.bar3 = 1'b1;
                n_pc       = '0;
                n_state    = i_stat.last ? S_FETCH : S_IDLE;
            end
            S_FETCH: begin
                unique case (instr.op)
                    OP_LD: begin
                        o_cmd.ld = 1'b1;
                        n_pc     = r_pc + 1'b1;
                    end
                    OP_END: n_state = S_EMIT;
                    default: begin
                        o_cmd.rd = 1'b1;
                        n_state  = S_OPER;
                    end
                endcase
            end
            S_OPER: begin
                unique case (instr.op)
                    OP_ADD, OP_SUB: begin
                        o_cmd.alu_wr  = 1'b1;
                        o_cmd.alu_sub = (instr.op == OP_SUB);
                        n_pc          = r_pc + 1'b1;
                        n_state       = S_FETCH;
                    end
                    OP_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        n_state         = S_MUL;
                    end
                    default: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                endcase
            end
            S_MUL: if (i_stat.mul_done) begin
                o_cmd.mul_wr = 1'b1;
                n_pc         = r_pc + 1'b1;
                n_state      = S_FETCH;
            end
            S_DIV: if (i_stat.div_done) begin
                o_cmd.res_wr = 1'b1;
                n_pc         = r_pc + 1'b1;
                n_state      = S_FETCH;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_pc       = '0;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_BAR1))
        else $error("accepted beat did not enter intake");

    a_mul_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (instr.op == OP_MUL))
        else $error("multiply wait on a non-multiply step");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> (r_state == S_IDLE && r_pc == '0))
        else $error("sequencer not rewound after emit");
`endif

endmodule

@@ hdl/bar_series_trend_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_series_trend_stats
// Linear slope, R squared, quadratic coefficient and net/total move ratio
// over a series of price bars.
// ----------------------------------------------------------------------------
// Intake: each bar is accepted, then passes the per-bar product/accumulate
//   steps S_BAR1, S_BAR2 and S_BAR3; busy stays high meanwhile, so no new
//   bar is taken until it is done. Fit: on a last bar the microprogram runs
//   on one shared shift-add multiplier and one bit-serial divider (192-bit
//   words); the result then shows on the outputs for one cycle with o_valid.
// Reset: synchronous, active low; clears the series sums and the sequencer.
//   The receiver cannot stall; each result beat is taken in its one cycle.
// ----------------------------------------------------------------------------
module bar_series_trend_stats import bstats_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_open_price,
    input  logic [31:0]        i_close_price,
    input  logic               i_last_bar,
    output logic               o_valid,
    output logic [10:0]        o_bar_count,
    output logic signed [63:0] o_trend_slope,
    output logic [16:0]        o_fit_quality,
    output logic signed [63:0] o_curvature,
    output logic [47:0]        o_noise_ratio,
    output logic               o_overflowed
);

    // command and status bundles between sequencer and datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: bar intake steps, then the fit program on the last bar
    bstats_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: running sums, register file, multiply and divide units
    bstats_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_open_price  (i_open_price),
        .i_close_price (i_close_price),
        .i_last_bar    (i_last_bar),
        .o_valid       (o_valid),
        .o_bar_count   (o_bar_count),
        .o_trend_slope (o_trend_slope),
        .o_fit_quality (o_fit_quality),
        .o_curvature   (o_curvature),
        .o_noise_ratio (o_noise_ratio),
        .o_overflowed  (o_overflowed)
    );

endmodule
